// ===== sv/mtenc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtenc_pkg
// Shared widths, reset values, register indexes and types for the multi-turn
// encoder speed loop.
// ----------------------------------------------------------------------------
package mtenc_pkg;

  // default parameter values
  localparam int ANGLE_BITS_DEF = 12;
  localparam int TURN_BITS_DEF  = 16;

  // fixed field widths
  localparam int POS_W      = 28;
  localparam int TURN_CNT_W = 16;
  localparam int QUAD_W     = 2;
  localparam int GAIN_W     = 16;
  localparam int FF_W       = 17;
  localparam int MAXSPD_W   = 16;
  localparam int SPEED_W    = 32;
  localparam int CFG_DATA_W = 28;
  localparam int CFG_IDX_W  = 2;

  // position range
  localparam int POS_MAX = 134217727;
  localparam int POS_MIN = -134217728;

  // register reset values
  localparam logic signed [POS_W-1:0]  TARGET_RST = POS_W'(762);
  localparam logic [GAIN_W-1:0]        GAIN_RST   = GAIN_W'(50);
  localparam logic signed [FF_W-1:0]   FF_RST     = '0;
  localparam logic [MAXSPD_W-1:0]      MAXSPD_RST = MAXSPD_W'(2000);

  // quadrant codes
  localparam logic [QUAD_W-1:0] QUAD_FIRST  = 2'd0;
  localparam logic [QUAD_W-1:0] QUAD_SECOND = 2'd1;
  localparam logic [QUAD_W-1:0] QUAD_THIRD  = 2'd2;
  localparam logic [QUAD_W-1:0] QUAD_FOURTH = 2'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET  = 2'd0,
    CFG_GAIN    = 2'd1,
    CFG_FF      = 2'd2,
    CFG_MAXSPD  = 2'd3
  } cfg_reg_t;

  // position result from the tracker
  typedef struct packed {
    logic signed [POS_W-1:0]    total;
    logic signed [TURN_CNT_W-1:0] turn_cnt;
    logic [QUAD_W-1:0]          quad;
  } pos_t;

endpackage

// ===== sv/mtenc_if.sv =====
// ----------------------------------------------------------------------------
// mtenc_in_if / mtenc_out_if
// Valid/ready channels for encoder samples and speed loop results.
// ----------------------------------------------------------------------------
interface mtenc_in_if
  import mtenc_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] raw_angle;

  modport source (output valid, output raw_angle, input ready);
  modport sink   (input valid, input raw_angle, output ready);
endinterface

interface mtenc_out_if
  import mtenc_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic signed [POS_W-1:0]      total_position;
  logic signed [TURN_CNT_W-1:0] turn_count;
  logic [QUAD_W-1:0]            quadrant;
  logic signed [SPEED_W-1:0]    speed_command;

  modport source (output valid, output total_position, output turn_count,
                  output quadrant, output speed_command, input ready);
  modport sink   (input valid, input total_position, input turn_count,
                  input quadrant, input speed_command, output ready);
endinterface

// ===== sv/mtenc_track.sv =====
// ----------------------------------------------------------------------------
// mtenc_track
// Zero reference, quadrant tracking and saturating turn counter. Gives the
// tared multi-turn position of the sample presented this cycle.
// ----------------------------------------------------------------------------
module mtenc_track
  import mtenc_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int TURN_BITS  = TURN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [ANGLE_BITS-1:0] raw,
  output pos_t                  pos
);

  localparam int TW  = TURN_BITS + ANGLE_BITS;
  localparam int XW  = (TW > POS_W) ? TW : POS_W;
  localparam int TCW = (TURN_BITS > TURN_CNT_W) ? TURN_BITS : TURN_CNT_W;

  localparam logic [ANGLE_BITS-1:0] QTR1 = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] QTR2 = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] QTR3 = QTR1 | QTR2;

  localparam logic signed [TURN_BITS-1:0] TMAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TMIN = {1'b1, {(TURN_BITS-1){1'b0}}};
  localparam logic signed [XW-1:0] PMAX = XW'(POS_MAX);
  localparam logic signed [XW-1:0] PMIN = XW'(POS_MIN);

  logic [ANGLE_BITS-1:0]        zero_ref_r;
  logic                         ref_taken_r;
  logic [QUAD_W-1:0]            last_q_r;
  logic signed [TURN_BITS-1:0]  turns_r;

  logic [ANGLE_BITS-1:0]        ref_cur;
  logic [ANGLE_BITS-1:0]        tared;
  logic [QUAD_W-1:0]            q;
  logic signed [TURN_BITS-1:0]  turns_nxt;
  logic signed [TW-1:0]         wide;
  logic signed [XW-1:0]         wide_x;
  logic signed [XW-1:0]         total_x;
  logic signed [TCW-1:0]        turns_x;

  // tare against the reference, first sample taring itself
  assign ref_cur = ref_taken_r ? zero_ref_r : raw;
  assign tared   = raw - ref_cur;

  // quadrant of the tared angle, upper bounds inclusive
  always_comb begin
    priority if (tared <= QTR1) q = QUAD_FIRST;
    else if (tared <= QTR2)     q = QUAD_SECOND;
    else if (tared <= QTR3)     q = QUAD_THIRD;
    else                        q = QUAD_FOURTH;
  end

  // turn counting on wrap between fourth and first quadrant
  always_comb begin
    turns_nxt = turns_r;
    if (ref_taken_r && last_q_r == QUAD_FOURTH && q == QUAD_FIRST && turns_r < TMAX) begin
      turns_nxt = turns_r + TURN_BITS'(1);
    end else if (ref_taken_r && last_q_r == QUAD_FIRST && q == QUAD_FOURTH
                 && turns_r > TMIN) begin
      turns_nxt = turns_r - TURN_BITS'(1);
    end
  end

  // multi-turn position with saturation
  assign wide   = {turns_nxt, tared};
  assign wide_x = XW'(wide);
  always_comb begin
    priority if (wide_x > PMAX) total_x = PMAX;
    else if (wide_x < PMIN)     total_x = PMIN;
    else                        total_x = wide_x;
  end

  assign turns_x      = TCW'(turns_nxt);
  assign pos.total    = total_x[POS_W-1:0];
  assign pos.turn_cnt = turns_x[TURN_CNT_W-1:0];
  assign pos.quad     = q;

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_ref_r  <= '0;
      ref_taken_r <= 1'b0;
      last_q_r    <= QUAD_FIRST;
      turns_r     <= '0;
    end else if (fire) begin
      zero_ref_r  <= ref_cur;
      ref_taken_r <= 1'b1;
      last_q_r    <= q;
      turns_r     <= turns_nxt;
    end
  end

endmodule

// ===== sv/multiturn_encoder_p_speed_loop_unit.sv =====
// ----------------------------------------------------------------------------
// multiturn_encoder_p_speed_loop_unit
// Multi-turn absolute encoder tracking with a proportional speed command.
// ----------------------------------------------------------------------------
// Takes one encoder sample per cycle while the output is not stalled and returns
// one result per sample, as a three-stage pipeline: position tracking,
// the gain multiplier, then scaling, feedforward and clamping. The first
// sample after reset sets the zero position. A stalled result stalls the
// whole pipeline, so in_if.ready follows the free state of the output
// register. Configuration writes are taken at any time but must only be made
// while no sample is in flight.
module multiturn_encoder_p_speed_loop_unit
  import mtenc_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int TURN_BITS  = TURN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mtenc_in_if.sink              in_if,
  mtenc_out_if.source           out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ERR_W  = POS_W + 1;
  localparam int PROD_W = GAIN_W + 1 + ERR_W;

  logic signed [POS_W-1:0] target_r;
  logic [GAIN_W-1:0]       gain_r;
  logic signed [FF_W-1:0]  ff_r;
  logic [MAXSPD_W-1:0]     maxspd_r;

  logic                    adv;
  logic                    fire;
  pos_t                    pos;

  logic                    s1_v_r;
  pos_t                    s1_r;
  logic                    s2_v_r;
  pos_t                    s2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                    out_v_r;
  pos_t                    out_pos_r;
  logic signed [SPEED_W-1:0] speed_r;

  logic signed [ERR_W-1:0]  err;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] corr;
  logic signed [PROD_W-1:0] sum;
  logic signed [PROD_W-1:0] max_x;
  logic signed [PROD_W-1:0] min_x;
  logic signed [SPEED_W-1:0] speed_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      gain_r   <= GAIN_RST;
      ff_r     <= FF_RST;
      maxspd_r <= MAXSPD_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_TARGET: target_r <= cfg_wdata[POS_W-1:0];
        CFG_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_FF:     ff_r     <= cfg_wdata[FF_W-1:0];
        CFG_MAXSPD: maxspd_r <= cfg_wdata[MAXSPD_W-1:0];
        default:    ;
      endcase
    end
  end

  // pipeline advances whenever the output register is free or being emptied
  assign adv         = !out_v_r || out_if.ready;
  assign in_if.ready = adv;
  assign fire        = in_if.valid && adv;

  mtenc_track #(
    .ANGLE_BITS (ANGLE_BITS),
    .TURN_BITS  (TURN_BITS)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .raw   (in_if.raw_angle),
    .pos   (pos)
  );

  // position error times gain
  assign err      = ERR_W'(target_r) - ERR_W'(s1_r.total);
  assign prod_nxt = $signed({1'b0, gain_r}) * err;

  // divide by 256 rounding toward zero, add feedforward, clamp
  assign corr  = (prod_r + (prod_r[PROD_W-1] ? PROD_W'(255) : PROD_W'(0))) >>> 8;
  assign sum   = PROD_W'(ff_r) + corr;
  assign max_x = PROD_W'($signed({1'b0, maxspd_r}));
  assign min_x = {{(PROD_W-SPEED_W+1){1'b1}}, {(SPEED_W-1){1'b0}}};
  always_comb begin
    priority if (sum > max_x) speed_nxt = SPEED_W'(max_x);
    else if (sum < min_x)     speed_nxt = SPEED_W'(min_x);
    else                      speed_nxt = SPEED_W'(sum);
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= fire;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r      <= pos;
      s2_r      <= s1_r;
      prod_r    <= prod_nxt;
      out_pos_r <= s2_r;
      speed_r   <= speed_nxt;
    end
  end

  assign out_if.valid          = out_v_r;
  assign out_if.total_position = out_pos_r.total;
  assign out_if.turn_count     = out_pos_r.turn_cnt;
  assign out_if.quadrant       = out_pos_r.quad;
  assign out_if.speed_command  = speed_r;

endmodule

// ===== sv/mtenc_chk.sv =====
// ----------------------------------------------------------------------------
// mtenc_chk
// Port-level checks for the multi-turn encoder speed loop, bound to the top.
// ----------------------------------------------------------------------------
module mtenc_chk
  import mtenc_pkg::*;
(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [POS_W-1:0]      total_position,
  input logic signed [TURN_CNT_W-1:0] turn_count,
  input logic [QUAD_W-1:0]            quadrant,
  input logic signed [SPEED_W-1:0]    speed_command
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(total_position)
      && $stable(speed_command) && $stable(turn_count) && $stable(quadrant))
    else $error("result beat changed while stalled");

  // an empty output register never blocks a sample
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // speed command never above the widest clamp
  a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> speed_command <= $signed(SPEED_W'(65535)))
    else $error("speed command above clamp");

  // position upper bits are the turn count
  a_turns_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> total_position[POS_W-1:POS_W-TURN_CNT_W] == turn_count)
    else $error("position and turn count disagree");

  // angles in the lower part of the first quarter land in quadrant one
  a_quad_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && total_position[11:10] == 2'b00 |-> quadrant == QUAD_FIRST)
    else $error("quadrant does not match angle");

endmodule

bind multiturn_encoder_p_speed_loop_unit mtenc_chk u_mtenc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .total_position (out_if.total_position),
  .turn_count     (out_if.turn_count),
  .quadrant       (out_if.quadrant),
  .speed_command  (out_if.speed_command)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-turn encoder speed loop. Encoder samples
// go in through a valid/ready driver fed from a sample queue, and a cycle
// model of the tracker and speed loop predicts each result beat. The results
// are checked field by field as they leave the block. Phases cover quadrant
// edges, turn crossings both ways, register extremes, speed clamping and
// turn counting in both directions.
// ----------------------------------------------------------------------------
module tb_top;
  import mtenc_pkg::*;

  localparam int QTR            = 1 << (ANGLE_BITS_DEF - 2);
  localparam int TURN_MAX       = (1 << (TURN_BITS_DEF - 1)) - 1;
  localparam int TURN_MIN       = -TURN_MAX - 1;
  // the limit lies well above the long receiver hold-off and the random stalls
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [POS_W-1:0]      total;
    logic signed [TURN_CNT_W-1:0] turns;
    logic [QUAD_W-1:0]            quad;
    logic signed [SPEED_W-1:0]    speed;
  } loop_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mtenc_in_if #(.ANGLE_BITS(ANGLE_BITS_DEF)) in_ch ();
  mtenc_out_if out_ch ();

  multiturn_encoder_p_speed_loop_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // register copies
  logic signed [POS_W-1:0]    tgt_pos = TARGET_RST;
  logic [GAIN_W-1:0]          kp      = GAIN_RST;
  logic signed [FF_W-1:0]     ff_spd  = FF_RST;
  logic [MAXSPD_W-1:0]        spd_cap = MAXSPD_RST;

  // tracker state copies
  logic [ANGLE_BITS_DEF-1:0]  zero_ref   = '0;
  bit                         zero_taken = 1'b0;
  bit                         quad_seen  = 1'b0;
  logic [QUAD_W-1:0]          last_quad  = QUAD_FIRST;
  int                         rev_count  = 0;

  logic [ANGLE_BITS_DEF-1:0]  angle_queue [$];
  loop_result_t               pending_results [$];
  logic [ANGLE_BITS_DEF-1:0]  ref_raw;
  logic [ANGLE_BITS_DEF-1:0]  walk_pos;

  int mismatches  = 0;
  int idle_cycles = 0;
  int send_gap    = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  int hold_req    = 0;
  bit no_gaps     = 1'b0;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // position tracking and speed command for one sample
  function automatic loop_result_t track_sample(input logic [ANGLE_BITS_DEF-1:0] raw);
    logic [ANGLE_BITS_DEF-1:0] tared;
    logic [QUAD_W-1:0]         q;
    longint                    total;
    longint                    corr;
    longint                    spd;
    loop_result_t              res;
    if (!zero_taken) begin
      zero_ref   = raw;
      zero_taken = 1'b1;
    end
    tared = raw - zero_ref;
    if (tared <= QTR) q = QUAD_FIRST;
    else if (tared <= 2 * QTR) q = QUAD_SECOND;
    else if (tared <= 3 * QTR) q = QUAD_THIRD;
    else q = QUAD_FOURTH;
    // fourth to first is a turn forward, first to fourth a turn back
    if (quad_seen && q == QUAD_FIRST && last_quad == QUAD_FOURTH && rev_count < TURN_MAX)
      rev_count++;
    else if (quad_seen && q == QUAD_FOURTH && last_quad == QUAD_FIRST && rev_count > TURN_MIN)
      rev_count--;
    last_quad = q;
    quad_seen = 1'b1;
    total = longint'(rev_count) * (longint'(1) << ANGLE_BITS_DEF) + longint'(tared);
    if (total > POS_MAX) total = POS_MAX;
    if (total < POS_MIN) total = POS_MIN;
    // integer division truncates toward zero
    corr = (longint'(kp) * (longint'(tgt_pos) - total)) / 256;
    spd  = longint'(ff_spd) + corr;
    if (spd > longint'(spd_cap)) spd = longint'(spd_cap);
    if (spd < -(longint'(1) << 31)) spd = -(longint'(1) << 31);
    res.total = total[POS_W-1:0];
    res.turns = rev_count[TURN_CNT_W-1:0];
    res.quad  = q;
    res.speed = spd[SPEED_W-1:0];
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random raw angle inside one quadrant of the tared circle
  function automatic logic [ANGLE_BITS_DEF-1:0] quad_angle(input logic [QUAD_W-1:0] q);
    int lo;
    int hi;
    lo = int'(q) * QTR + ((q == QUAD_FIRST) ? 0 : 1);
    hi = (q == QUAD_FOURTH) ? (1 << ANGLE_BITS_DEF) - 1 : (int'(q) + 1) * QTR;
    return ANGLE_BITS_DEF'($urandom_range(lo, hi)) + ref_raw;
  endfunction

  task automatic check_field(input string fname, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TARGET: tgt_pos = val[POS_W-1:0];
      CFG_GAIN:   kp      = val[GAIN_W-1:0];
      CFG_FF:     ff_spd  = val[FF_W-1:0];
      CFG_MAXSPD: spd_cap = val[MAXSPD_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_loop(input logic [POS_W-1:0] tgt, input logic [GAIN_W-1:0] g,
                          input logic [FF_W-1:0] f, input logic [MAXSPD_W-1:0] m);
    write_reg(CFG_TARGET, CFG_DATA_W'(tgt));
    write_reg(CFG_GAIN, CFG_DATA_W'(g));
    write_reg(CFG_FF, CFG_DATA_W'(f));
    write_reg(CFG_MAXSPD, CFG_DATA_W'(m));
  endtask

  // random walk around the circle with a directional drift, plus some jumps
  task automatic push_walk(input int n, input int drift);
    logic [ANGLE_BITS_DEF-1:0] step;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        walk_pos = ANGLE_BITS_DEF'($urandom());
      end else begin
        step = ANGLE_BITS_DEF'($urandom_range(0, 1400));
        if (int'($urandom_range(0, 99)) < 50 + drift) walk_pos = walk_pos + step;
        else walk_pos = walk_pos - step;
      end
      angle_queue.push_back(walk_pos + ref_raw);
    end
  endtask

  // three samples per turn: forward via 4,1,3 and backward via 1,4,2
  task automatic push_spin(input int n, input bit forward);
    for (int i = 0; i < n; i++) begin
      if (forward) begin
        angle_queue.push_back(quad_angle(QUAD_FOURTH));
        angle_queue.push_back(quad_angle(QUAD_FIRST));
        angle_queue.push_back(quad_angle(QUAD_THIRD));
      end else begin
        angle_queue.push_back(quad_angle(QUAD_FIRST));
        angle_queue.push_back(quad_angle(QUAD_FOURTH));
        angle_queue.push_back(quad_angle(QUAD_SECOND));
      end
    end
  endtask

  task automatic drain();
    while (angle_queue.size() != 0 || pending_results.size() != 0) @(posedge clk);
  endtask

  // sample driver
  always @(posedge clk) begin : drive_p
    logic nxt_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(track_sample(in_ch.raw_angle));
        void'(angle_queue.pop_front());
        send_gap = pick_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
        nxt_valid = 1'b0;
      end else begin
        nxt_valid = (angle_queue.size() != 0);
      end
      in_ch.valid <= nxt_valid;
      if (nxt_valid) in_ch.raw_angle <= angle_queue[0];
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin : check_p
    loop_result_t exp_r;
    logic         nxt_ready;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, expected none actual total %0d",
                   $time, out_ch.total_position);
        end else begin
          exp_r = pending_results.pop_front();
          check_field("total_position", exp_r.total, out_ch.total_position);
          check_field("turn_count", exp_r.turns, out_ch.turn_count);
          check_field("quadrant", exp_r.quad, out_ch.quadrant);
          check_field("speed_command", exp_r.speed, out_ch.speed_command);
        end
        stall_left = pick_gap();
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ch.ready <= nxt_ready;
    end
  end

  // watchdog on beats in either direction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus sequence
  initial begin : stimulus_p
    int dir_offsets [$] = '{0, 1024, 1025, 2048, 2049, 3072, 3073, 4095, 0, 4095, 0,
                            2049, 3073, 0, 1};
    in_ch.valid     = 1'b0;
    in_ch.raw_angle = '0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_TARGET;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    ref_raw         = ANGLE_BITS_DEF'($urandom());
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reference capture, quadrant edges, crossings both ways, raw extremes
    @(negedge clk);
    foreach (dir_offsets[i]) angle_queue.push_back(ANGLE_BITS_DEF'(dir_offsets[i]) + ref_raw);
    angle_queue.push_back('0);
    angle_queue.push_back('1);
    walk_pos = ~ref_raw;
    drain();

    // maximum gain, most negative feedforward, with a long receiver hold-off
    set_loop('0, 16'hFFFF, 17'h10000, 16'hFFFF);
    @(negedge clk);
    push_walk(75, 20);
    hold_req = 300;
    drain();

    // furthest target, unit gain, zero speed cap
    set_loop(POS_W'(POS_MAX), 16'd1, 17'h0FFFF, 16'd0);
    @(negedge clk);
    push_walk(75, -20);
    drain();

    // most negative target drives the command into its lower bound
    set_loop(POS_W'(POS_MIN), 16'hFFFF, '0, 16'hFFFF);
    @(negedge clk);
    push_walk(75, 0);
    drain();

    // zero gain leaves only the feedforward
    set_loop(POS_W'($urandom()), '0, FF_W'($urandom()), MAXSPD_W'($urandom()));
    @(negedge clk);
    push_walk(75, 30);
    drain();

    // random settings, the first batch without gaps
    for (int p = 0; p < 3; p++) begin
      set_loop(POS_W'($urandom()), GAIN_W'($urandom()), FF_W'($urandom()),
               MAXSPD_W'($urandom()));
      @(negedge clk);
      no_gaps = (p == 0);
      push_walk(75, int'($urandom_range(0, 80)) - 40);
      drain();
    end

    // spin forward a few turns, then back past the starting count
    set_loop('0, 16'hFFFF, '0, 16'hFFFF);
    @(negedge clk);
    no_gaps = 1'b1;
    push_spin(12, 1'b1);
    push_spin(16, 1'b0);
    drain();
    @(negedge clk);
    no_gaps = 1'b0;

    // random settings after the spin
    set_loop(POS_W'($urandom()), GAIN_W'($urandom()), FF_W'($urandom()),
             MAXSPD_W'($urandom()));
    @(negedge clk);
    push_walk(75, -30);
    drain();

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
